[rtl/fowc_pkg.sv]
// Package for the frame offset clamp-or-wrap block: field widths, register
// indexes and the item and control structs; imported by all rtl files.
// No dependencies.
package fowc_pkg;

  // Default width of the internal frame arithmetic.
  localparam int FOWC_FRAME_WIDTH = 32;

  // Fixed widths of the channel fields.
  localparam int FRAME_FIELD_W = 32;
  localparam int OFFSET_W      = 32;

  // Offset magnitude width and remainder bits resolved per divider stage.
  localparam int MAG_W    = 32;
  localparam int DIV_BITS = 2;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_FRAME = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAST_FRAME  = 2'd1;

  typedef struct packed {
    logic [FRAME_FIELD_W-1:0] current_frame;
    logic signed [OFFSET_W-1:0] frame_offset;
    logic                     mode;
  } fowc_in_t;

  typedef struct packed {
    logic [FRAME_FIELD_W-1:0] new_frame;
    logic                     range_error;
  } fowc_out_t;

  // Per-item flags that travel down the pipeline.
  typedef struct packed {
    logic err;   // range inverted, full length, or current frame outside
    logic neg;   // offset is negative
    logic wrap;  // loop mode
    logic zero;  // offset is zero
  } fowc_ctl_t;

endpackage

[rtl/fowc_prep.sv]
// Input stage: range checks, distances to the range ends and offset magnitude.
// Depends on fowc_pkg.
module fowc_prep import fowc_pkg::*; #(
  parameter int FRAME_WIDTH = FOWC_FRAME_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  fowc_in_t                 in_item,
  input  logic [FRAME_FIELD_W-1:0] first_frame,
  input  logic [FRAME_FIELD_W-1:0] last_frame,
  output logic                     out_valid,
  input  logic                     out_ready,
  output fowc_ctl_t                out_ctl,
  output logic [FRAME_WIDTH-1:0]   out_cur,
  output logic [FRAME_WIDTH-1:0]   out_first,
  output logic [FRAME_WIDTH-1:0]   out_last,
  output logic [FRAME_WIDTH-1:0]   out_pos,
  output logic [FRAME_WIDTH-1:0]   out_to_end,
  output logic [FRAME_WIDTH-1:0]   out_len,
  output logic [MAG_W-1:0]         out_mag
);

  logic                   valid_r;
  fowc_ctl_t              ctl_r, ctl_nxt;
  logic [FRAME_WIDTH-1:0] cur_r, cur_nxt;
  logic [FRAME_WIDTH-1:0] first_r, first_nxt;
  logic [FRAME_WIDTH-1:0] last_r, last_nxt;
  logic [FRAME_WIDTH-1:0] pos_r, pos_nxt;
  logic [FRAME_WIDTH-1:0] to_end_r, to_end_nxt;
  logic [FRAME_WIDTH-1:0] len_r, len_nxt;
  logic [MAG_W-1:0]       mag_r, mag_nxt;
  logic [MAG_W-1:0]       raw;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    first_nxt  = FRAME_WIDTH'(first_frame);
    last_nxt   = FRAME_WIDTH'(last_frame);
    cur_nxt    = FRAME_WIDTH'(in_item.current_frame);
    raw        = MAG_W'(in_item.frame_offset);
    pos_nxt    = cur_nxt - first_nxt;
    to_end_nxt = last_nxt - cur_nxt;
    len_nxt    = last_nxt - first_nxt + FRAME_WIDTH'(1);
    ctl_nxt.neg  = raw[MAG_W-1];
    ctl_nxt.wrap = in_item.mode;
    ctl_nxt.zero = (raw == '0);
    // The most negative offset negates to itself, which as unsigned is its magnitude.
    mag_nxt = ctl_nxt.neg ? (~raw + MAG_W'(1)) : raw;
    ctl_nxt.err = (first_nxt > last_nxt) || (cur_nxt < first_nxt) || (cur_nxt > last_nxt) ||
                  ((last_nxt - first_nxt) == {FRAME_WIDTH{1'b1}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ctl_r    <= ctl_nxt;
      cur_r    <= cur_nxt;
      first_r  <= first_nxt;
      last_r   <= last_nxt;
      pos_r    <= pos_nxt;
      to_end_r <= to_end_nxt;
      len_r    <= len_nxt;
      mag_r    <= mag_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_ctl    = ctl_r;
  assign out_cur    = cur_r;
  assign out_first  = first_r;
  assign out_last   = last_r;
  assign out_pos    = pos_r;
  assign out_to_end = to_end_r;
  assign out_len    = len_r;
  assign out_mag    = mag_r;

endmodule

[rtl/fowc_div_stage.sv]
// One stage of the restoring remainder pipeline: takes DIV_BITS dividend bits
// of the offset magnitude and reduces the partial remainder by the range length.
// Depends on fowc_pkg.
module fowc_div_stage import fowc_pkg::*; #(
  parameter int FRAME_WIDTH = FOWC_FRAME_WIDTH,
  parameter int STAGE       = 0,
  parameter int SIDE_W      = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [FRAME_WIDTH-1:0] in_len,
  input  logic [MAG_W-1:0]       in_mag,
  input  logic [FRAME_WIDTH-1:0] in_rem,
  input  logic [SIDE_W-1:0]      in_side,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [FRAME_WIDTH-1:0] out_len,
  output logic [MAG_W-1:0]       out_mag,
  output logic [FRAME_WIDTH-1:0] out_rem,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int TOP_BIT = MAG_W - 1 - STAGE * DIV_BITS;

  logic                   valid_r;
  logic [FRAME_WIDTH-1:0] len_r;
  logic [MAG_W-1:0]       mag_r;
  logic [FRAME_WIDTH-1:0] rem_r, rem_nxt;
  logic [SIDE_W-1:0]      side_r;
  logic [FRAME_WIDTH:0]   trial;

  assign in_ready = !valid_r || out_ready;

  // The partial remainder stays below the length, so one subtract per bit suffices.
  always_comb begin
    rem_nxt = in_rem;
    trial   = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem_nxt, in_mag[TOP_BIT - i]};
      if (trial >= {1'b0, in_len}) begin
        trial = trial - {1'b0, in_len};
      end
      rem_nxt = trial[FRAME_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      len_r  <= in_len;
      mag_r  <= in_mag;
      rem_r  <= rem_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_len   = len_r;
  assign out_mag   = mag_r;
  assign out_rem   = rem_r;
  assign out_side  = side_r;

endmodule

[rtl/fowc_finish.sv]
// Final two stages: clamp result and wrapped position, then the output
// register with pass-through for errors and zero offsets. Depends on fowc_pkg.
module fowc_finish import fowc_pkg::*; #(
  parameter int FRAME_WIDTH = FOWC_FRAME_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  fowc_ctl_t              in_ctl,
  input  logic [FRAME_WIDTH-1:0] in_cur,
  input  logic [FRAME_WIDTH-1:0] in_first,
  input  logic [FRAME_WIDTH-1:0] in_last,
  input  logic [FRAME_WIDTH-1:0] in_pos,
  input  logic [FRAME_WIDTH-1:0] in_to_end,
  input  logic [FRAME_WIDTH-1:0] in_len,
  input  logic [MAG_W-1:0]       in_mag,
  input  logic [FRAME_WIDTH-1:0] in_rem,
  output logic                   out_valid,
  input  logic                   out_ready,
  output fowc_out_t              out_item
);

  localparam int XW = ((FRAME_WIDTH > MAG_W) ? FRAME_WIDTH : MAG_W) + 1;

  logic                   valid1_r;
  fowc_ctl_t              ctl1_r;
  logic [FRAME_WIDTH-1:0] cur1_r;
  logic [FRAME_WIDTH-1:0] first1_r;
  logic [FRAME_WIDTH-1:0] clamp1_r, clamp1_nxt;
  logic [FRAME_WIDTH-1:0] np1_r, np1_nxt;
  logic                   f1_ready;

  logic                   valid2_r;
  fowc_out_t              out_r, out_nxt;
  logic                   f2_ready;
  logic [FRAME_WIDTH-1:0] res;

  logic [XW-1:0]          mag_x;

  assign f2_ready = !valid2_r || out_ready;
  assign f1_ready = !valid1_r || f2_ready;
  assign in_ready = f1_ready;

  // Clamp and wrap candidates. The chosen sums and differences always land
  // inside the range, so truncation to the frame width is exact.
  always_comb begin
    mag_x = XW'(in_mag);
    if (!in_ctl.neg) begin
      clamp1_nxt = (mag_x >= XW'(in_to_end)) ? in_last
                                             : FRAME_WIDTH'(XW'(in_cur) + mag_x);
      np1_nxt    = (in_rem > in_to_end) ? (in_rem - in_to_end - FRAME_WIDTH'(1))
                                        : (in_pos + in_rem);
    end else begin
      clamp1_nxt = (mag_x >= XW'(in_pos)) ? in_first
                                          : FRAME_WIDTH'(XW'(in_cur) - mag_x);
      np1_nxt    = (in_rem <= in_pos) ? (in_pos - in_rem)
                                      : (in_pos + in_len - in_rem);
    end
  end

  always_comb begin
    if (ctl1_r.err || ctl1_r.zero) begin
      res = cur1_r;
    end else if (ctl1_r.wrap) begin
      res = first1_r + np1_r;
    end else begin
      res = clamp1_r;
    end
    out_nxt.new_frame   = FRAME_FIELD_W'(res);
    out_nxt.range_error = ctl1_r.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else begin
      if (f1_ready) begin
        valid1_r <= in_valid;
      end
      if (f2_ready) begin
        valid2_r <= valid1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && f1_ready) begin
      ctl1_r   <= in_ctl;
      cur1_r   <= in_cur;
      first1_r <= in_first;
      clamp1_r <= clamp1_nxt;
      np1_r    <= np1_nxt;
    end
    if (valid1_r && f2_ready) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = valid2_r;
  assign out_item  = out_r;

endmodule

[rtl/frame_offset_clamp_or_wrap.sv]
// Top level of the frame offset clamp-or-wrap block: configuration registers
// and the pipeline. Depends on fowc_pkg, fowc_prep, fowc_div_stage, fowc_finish.
//
// Usage: an item on the in_ channel carries a current frame, a signed offset
// and a mode bit. The result on the out_ channel is the moved frame inside the
// inclusive range [first_frame, last_frame], clamped at the ends in clamp mode
// or wrapped modulo the range length in loop mode, plus an error flag when the
// range or the current frame is invalid (the frame then passes through).
// The cfg_ channel writes first_frame (index 0) and last_frame (index 1); it is
// always ready, and writes belong in periods when no item is in flight.
// An accepted item passes through the input stage, the remainder stages and the
// clamp and output registers of the finish stage before its result can be
// accepted. The remainder pipeline resolves two offset bits per stage, which
// sets its number of stages. One item can enter every cycle while the receiver
// keeps out_ready high.
// Reset clears both range registers to 0 and empties the pipeline.
// When the receiver stalls, each stage holds its item while empty stages ahead
// of it keep filling, so in_ready drops only once every stage is occupied.
module frame_offset_clamp_or_wrap import fowc_pkg::*; #(
  parameter int FRAME_WIDTH = FOWC_FRAME_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  fowc_in_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output fowc_out_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [FRAME_FIELD_W-1:0] cfg_data
);

  localparam int DIV_STAGES = MAG_W / DIV_BITS;
  localparam int SIDE_W     = $bits(fowc_ctl_t) + 5 * FRAME_WIDTH;

  logic [FRAME_FIELD_W-1:0] first_frame_r, first_frame_nxt;
  logic [FRAME_FIELD_W-1:0] last_frame_r, last_frame_nxt;

  fowc_ctl_t              prep_ctl;
  logic [FRAME_WIDTH-1:0] prep_cur, prep_first, prep_last, prep_pos, prep_to_end;

  logic                   div_valid [DIV_STAGES+1];
  logic                   div_ready [DIV_STAGES+1];
  logic [FRAME_WIDTH-1:0] div_len   [DIV_STAGES+1];
  logic [MAG_W-1:0]       div_mag   [DIV_STAGES+1];
  logic [FRAME_WIDTH-1:0] div_rem   [DIV_STAGES+1];
  logic [SIDE_W-1:0]      div_side  [DIV_STAGES+1];

  fowc_ctl_t              fin_ctl;
  logic [FRAME_WIDTH-1:0] fin_cur, fin_first, fin_last, fin_pos, fin_to_end;

  assign cfg_ready = 1'b1;

  always_comb begin
    first_frame_nxt = first_frame_r;
    last_frame_nxt  = last_frame_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_FIRST_FRAME: first_frame_nxt = cfg_data;
        CFG_LAST_FRAME:  last_frame_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_frame_r <= '0;
      last_frame_r  <= '0;
    end else begin
      first_frame_r <= first_frame_nxt;
      last_frame_r  <= last_frame_nxt;
    end
  end

  fowc_prep #(.FRAME_WIDTH(FRAME_WIDTH)) u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_data),
    .first_frame (first_frame_r),
    .last_frame  (last_frame_r),
    .out_valid   (div_valid[0]),
    .out_ready   (div_ready[0]),
    .out_ctl     (prep_ctl),
    .out_cur     (prep_cur),
    .out_first   (prep_first),
    .out_last    (prep_last),
    .out_pos     (prep_pos),
    .out_to_end  (prep_to_end),
    .out_len     (div_len[0]),
    .out_mag     (div_mag[0])
  );

  assign div_rem[0]  = '0;
  assign div_side[0] = {prep_ctl, prep_cur, prep_first, prep_last, prep_pos, prep_to_end};

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    fowc_div_stage #(
      .FRAME_WIDTH (FRAME_WIDTH),
      .STAGE       (g),
      .SIDE_W      (SIDE_W)
    ) u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (div_valid[g]),
      .in_ready  (div_ready[g]),
      .in_len    (div_len[g]),
      .in_mag    (div_mag[g]),
      .in_rem    (div_rem[g]),
      .in_side   (div_side[g]),
      .out_valid (div_valid[g+1]),
      .out_ready (div_ready[g+1]),
      .out_len   (div_len[g+1]),
      .out_mag   (div_mag[g+1]),
      .out_rem   (div_rem[g+1]),
      .out_side  (div_side[g+1])
    );
  end

  assign {fin_ctl, fin_cur, fin_first, fin_last, fin_pos, fin_to_end} = div_side[DIV_STAGES];

  fowc_finish #(.FRAME_WIDTH(FRAME_WIDTH)) u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid[DIV_STAGES]),
    .in_ready  (div_ready[DIV_STAGES]),
    .in_ctl    (fin_ctl),
    .in_cur    (fin_cur),
    .in_first  (fin_first),
    .in_last   (fin_last),
    .in_pos    (fin_pos),
    .in_to_end (fin_to_end),
    .in_len    (div_len[DIV_STAGES]),
    .in_mag    (div_mag[DIV_STAGES]),
    .in_rem    (div_rem[DIV_STAGES]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_data)
  );

  // An accepted item always lands in the input stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> div_valid[0])
    else $error("accepted item did not enter the input stage");

  // Back pressure reaches the input only when the pipeline is full.
  a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> div_valid[0] && div_valid[DIV_STAGES / 2] && div_valid[DIV_STAGES] &&
                  out_valid)
    else $error("input stalled while the pipeline had a free stage");

  // Reset leaves no result on the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !div_valid[0])
    else $error("pipeline not empty after reset");

endmodule

[dv/frame_offset_clamp_or_wrap_test.sv]
// Self-checking testbench for frame_offset_clamp_or_wrap: clamp and loop moves
// over several ranges, with random idling on both channels. Depends on fowc_pkg
// and the rtl of frame_offset_clamp_or_wrap.
module frame_offset_clamp_or_wrap_test import fowc_pkg::*; ();

  localparam logic MODE_CLAMP = 1'b0;
  localparam logic MODE_LOOP  = 1'b1;
  localparam logic [63:0] FRAME_MASK = 64'hFFFF_FFFF;
  localparam int DRAIN_CYCLES = 25;
  localparam int PHASE_ITEMS = 100;

  // Holds the range registers and the queue of expected moved frames.
  class frame_move_board;
    logic [63:0] range_lo;
    logic [63:0] range_hi;
    fowc_out_t moved_q[$];
    int unsigned errors;

    function new();
      range_lo = '0;
      range_hi = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
      if (idx == CFG_FIRST_FRAME) range_lo = {32'd0, val};
      else if (idx == CFG_LAST_FRAME) range_hi = {32'd0, val};
    endfunction

    function fowc_out_t move_frame(fowc_in_t d);
      logic [63:0] cur, raw, mag, len, pos, r, np, res;
      logic neg;
      fowc_out_t o;
      cur = {32'd0, d.current_frame};
      raw = {32'd0, d.frame_offset};
      neg = raw[31];
      mag = neg ? (64'h1_0000_0000 - raw) : raw;
      res = cur;
      o.range_error = 1'b0;
      if (range_lo > range_hi || cur < range_lo || cur > range_hi ||
          (range_hi - range_lo) == FRAME_MASK) begin
        o.range_error = 1'b1;
      end else if (mag != 0) begin
        if (d.mode == MODE_CLAMP) begin
          if (!neg) res = (mag >= range_hi - cur) ? range_hi : cur + mag;
          else res = (mag >= cur - range_lo) ? range_lo : cur - mag;
        end else begin
          len = range_hi - range_lo + 1;
          pos = cur - range_lo;
          r = mag % len;
          if (!neg) np = (r >= len - pos) ? pos + r - len : pos + r;
          else np = (r <= pos) ? pos - r : pos + (len - r);
          res = range_lo + np;
        end
      end
      o.new_frame = res[31:0];
      return o;
    endfunction

    function void note_item(fowc_in_t d);
      moved_q.push_back(move_frame(d));
    endfunction

    function int pending();
      return moved_q.size();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(fowc_out_t got);
      fowc_out_t want;
      if (moved_q.size() == 0) begin
        report($sformatf("result %h/%b with no item pending", got.new_frame,
                         got.range_error));
      end else begin
        want = moved_q.pop_front();
        if (got.new_frame !== want.new_frame)
          report($sformatf("new_frame %h, expected %h", got.new_frame, want.new_frame));
        if (got.range_error !== want.range_error)
          report($sformatf("range_error %b, expected %b", got.range_error,
                           want.range_error));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  fowc_in_t in_data;
  logic out_valid;
  logic out_ready;
  fowc_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [FRAME_FIELD_W-1:0] cfg_data;

  frame_move_board board = new();
  bit calm = 1'b0;

  frame_offset_clamp_or_wrap dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: checks each accepted result and stalls at random.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) board.check_result(out_data);
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 21);
    end
  end

  // The caller stands at a rising edge; valid stays high into the next item.
  task automatic send_item(input fowc_in_t d);
    if (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    board.note_item(d);
  endtask

  task automatic send(input logic [31:0] cur, input logic [31:0] offs, input logic mode);
    fowc_in_t d;
    d.current_frame = cur;
    d.frame_offset = offs;
    d.mode = mode;
    send_item(d);
  endtask

  // Holds the sender until every pending item has come back, then lets the
  // pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_range(input logic [31:0] lo, input logic [31:0] hi);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FIRST_FRAME;
    cfg_data <= lo;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(CFG_FIRST_FRAME, lo);
    cfg_index <= CFG_LAST_FRAME;
    cfg_data <= hi;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(CFG_LAST_FRAME, hi);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_offset(logic [63:0] len);
    int unsigned sel;
    logic [63:0] v;
    sel = $urandom_range(99);
    if (sel < 5) return 32'd0;
    if (sel < 12) begin
      case ($urandom_range(3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'hFFFF_FFFF;
        default: return 32'd1;
      endcase
    end
    if (sel < 45) v = 64'($urandom_range(0, (len > 1000) ? 1000 : len + 2));
    else if (sel < 65) v = len * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
    else return $urandom;
    if (v > 64'h7FFF_FFFF) v = {32'd0, $urandom_range(0, 32'h7FFF_FFFF)};
    return $urandom_range(1) ? -v[31:0] : v[31:0];
  endfunction

  // Mostly frames inside the range, with the ends and some strays outside.
  task automatic send_random();
    logic [63:0] lo, hi, len, cur;
    logic ok;
    int unsigned sel;
    lo = board.range_lo;
    hi = board.range_hi;
    ok = (lo <= hi) && (hi - lo != FRAME_MASK);
    len = ok ? hi - lo + 1 : 64'd100;
    sel = $urandom_range(99);
    if (sel < 10) cur = lo;
    else if (sel < 20) cur = hi;
    else if (sel < 85 && ok) cur = lo + ({32'd0, $urandom} % len);
    else begin
      case ($urandom_range(2))
        0: cur = lo - 1;
        1: cur = hi + 1;
        default: cur = {32'd0, $urandom};
      endcase
    end
    send(cur[31:0], pick_offset(len), 1'($urandom_range(1)));
  endtask

  initial begin
    logic [31:0] lo_tab [10];
    logic [31:0] hi_tab [10];
    logic [31:0] a, b;
    lo_tab = '{32'd1000, 32'd0, 32'hFFFF_FFFF, 32'd5, 32'd0, 32'd1, 32'd7,
               32'h8000_0000, 32'd0, 32'd0};
    hi_tab = '{32'd1999, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd4, 32'hFFFF_FFFE,
               32'hFFFF_FFFF, 32'd9, 32'h7FFF_FFFF, 32'd0, 32'd0};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_FIRST_FRAME;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers still hold their reset values: a one-frame range at zero.
    for (int i = 0; i < 60; i++) send_random();
    drain();

    write_range(32'd1000, 32'd1999);
    send(32'd1000, 32'd0, MODE_CLAMP);
    send(32'd1500, 32'd1, MODE_CLAMP);
    send(32'd1500, 32'hFFFF_FFFF, MODE_CLAMP);
    send(32'd1999, 32'd1, MODE_CLAMP);
    send(32'd1000, 32'hFFFF_FFFF, MODE_CLAMP);
    send(32'd1500, 32'd499, MODE_CLAMP);
    send(32'd1500, -32'd500, MODE_CLAMP);
    send(32'd1500, 32'h7FFF_FFFF, MODE_CLAMP);
    send(32'd1500, 32'h8000_0000, MODE_CLAMP);
    send(32'd1999, 32'd1, MODE_LOOP);
    send(32'd1000, 32'hFFFF_FFFF, MODE_LOOP);
    send(32'd1500, 32'd1000, MODE_LOOP);
    send(32'd1500, -32'd1000, MODE_LOOP);
    send(32'd1500, 32'd2499, MODE_LOOP);
    send(32'd1500, 32'h7FFF_FFFF, MODE_LOOP);
    send(32'd1500, 32'h8000_0000, MODE_LOOP);
    send(32'd1700, 32'd0, MODE_LOOP);
    send(32'd999, 32'd3, MODE_CLAMP);
    send(32'd2000, 32'hFFFF_FFFD, MODE_LOOP);
    send(32'd0, 32'd1, MODE_LOOP);
    send(32'hFFFF_FFFF, 32'h8000_0000, MODE_CLAMP);

    for (int p = 0; p < 10; p++) begin
      if (p == 8) begin
        a = $urandom;
        b = $urandom;
        lo_tab[p] = (a < b) ? a : b;
        hi_tab[p] = (a < b) ? b : a;
      end else if (p == 9) begin
        a = $urandom;
        lo_tab[p] = a;
        hi_tab[p] = (a > 32'hFFFF_FFEB) ? 32'hFFFF_FFFF : a + $urandom_range(0, 20);
      end
      if (p != 0) begin
        drain();
        write_range(lo_tab[p], hi_tab[p]);
      end
      // A long stretch with both sides always ready.
      calm = (p == 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == 50) drain();
        send_random();
      end
    end
    calm = 1'b0;
    drain();

    if (board.errors == 0) begin
      $display("frame_offset_clamp_or_wrap test passed");
    end else begin
      $display("frame_offset_clamp_or_wrap test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("frame_offset_clamp_or_wrap test failed");
    $finish;
  end

endmodule
